>>> design/lpds_pkg.sv
// ----------------------------------------------------------------------------
// lpds_pkg: shared types and constants for the line position steering block
// Field types, operation and result codes, and reset values used by the
// top level and the drive update datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package lpds_pkg;

  // payload types
  typedef logic        [7:0]  luma_t;
  typedef logic        [15:0] gain_t;
  typedef logic signed [14:0] err_t;
  typedef logic signed [15:0] drive_t;

  // operation bit of an input word
  localparam logic OP_CAL   = 1'b0;
  localparam logic OP_TRACK = 1'b1;

  // kind of a result word
  localparam logic KIND_THRESHOLD = 1'b0;
  localparam logic KIND_DRIVE     = 1'b1;

  // reset values
  localparam gain_t  GAIN_RESET  = 16'd328;
  localparam drive_t LEFT_RESET  = 16'sd0;
  localparam drive_t RIGHT_RESET = 16'sd100;
  localparam luma_t  MIN_RESET   = 8'd255;
  localparam luma_t  MAX_RESET   = 8'd0;

  // error accumulator limits
  localparam err_t ERR_MAX = 15'sd16383;
  localparam err_t ERR_MIN = -15'sd16384;

endpackage

`default_nettype wire

>>> design/line_position_derivative_steer_unit.sv
// ----------------------------------------------------------------------------
// line_position_derivative_steer_unit: camera row line tracker and steering
// Thresholds a luminance row and turns the line position into drive updates.
// ----------------------------------------------------------------------------
// Usage:
//   Input words are pixels of one row in column order (in_operation selects
//   calibration or tracking, in_row_end marks the last pixel). A calibration
//   row sets the threshold to the midpoint of its min and max; a tracking row
//   sums column weights of bright pixels and, at its end, applies the gain
//   times the error change to the left and right drives.
//   Only a row-end pixel produces a result word on the out_ channel.
//   cfg_wr_en / cfg_wr_data load the Q0.16 derivative gain; write it idle.
// Timing:
//   One pixel per cycle sustained while in_stall is low. A pixel is held in
//   an input register, its state update and the drive multiply run in that cycle,
//   and the result word is registered and valid in the cycle after it.
//   The per-row state loop (error accumulate, drive update) closes
//   combinationally around the state registers, which sets the one-pixel-per-cycle figure.
// Reset / stall:
//   Synchronous active-low reset clears row state, threshold, drives
//   (right drive to 100) and loads the default gain. in_stall rises only
//   when a row-end pixel waits while the result register is full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module line_position_derivative_steer_unit
  import lpds_pkg::*;
#(
  parameter int ROW_WIDTH = 320
) (
  input  wire         clk,
  input  wire         rst_n,
  // pixel input channel
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         in_operation,
  input  wire luma_t  in_luma,
  input  wire         in_row_end,
  // result channel
  output logic        out_valid,
  input  wire         out_stall,
  output logic        out_result_kind,
  output luma_t       out_threshold_out,
  output err_t        out_line_error,
  output drive_t      out_left_drive_out,
  output drive_t      out_right_drive_out,
  // gain register write
  input  wire         cfg_wr_en,
  input  wire gain_t  cfg_wr_data
);

  localparam int CW = $clog2(ROW_WIDTH + 1);
  localparam int WW = CW + 1;
  localparam logic [CW-1:0] COL_MAX  = CW'(ROW_WIDTH);
  localparam logic [CW-1:0] COL_HALF = CW'(ROW_WIDTH / 2);

  // input register
  logic          s1_valid_r;
  logic          s1_op_r;
  luma_t         s1_luma_r;
  logic          s1_row_end_r;
  logic          s1_go;
  logic          s1_fire;

  // block state
  gain_t         gain_r;
  luma_t         row_max_r, row_max_nxt;
  luma_t         row_min_r, row_min_nxt;
  luma_t         threshold_r, threshold_nxt;
  logic [CW-1:0] column_r, column_nxt;
  err_t          error_sum_r, error_sum_nxt;
  err_t          prev_error_r, prev_error_nxt;
  drive_t        left_r, left_nxt;
  drive_t        right_r, right_nxt;

  // per-pixel values
  luma_t              max_pix, min_pix, thr_new;
  logic [8:0]         mm_sum;
  logic               col_live;
  logic signed [WW-1:0] weight;
  logic signed [15:0] err_acc;
  err_t               err_pix;
  drive_t             left_calc, right_calc;

  // result register
  logic          out_valid_r;
  logic          out_kind_r,  out_kind_nxt;
  luma_t         out_thr_r,   out_thr_nxt;
  err_t          out_err_r,   out_err_nxt;
  drive_t        out_left_r,  out_left_nxt;
  drive_t        out_right_r, out_right_nxt;

  // handshake: only a row-end pixel needs the result slot
  assign s1_go    = !(s1_row_end_r && out_valid_r && out_stall);
  assign s1_fire  = s1_valid_r && s1_go;
  assign in_stall = s1_valid_r && !s1_go;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall) begin
      s1_op_r      <= in_operation;
      s1_luma_r    <= in_luma;
      s1_row_end_r <= in_row_end;
    end
  end

  // gain register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r <= GAIN_RESET;
    end else if (cfg_wr_en) begin
      gain_r <= cfg_wr_data;
    end
  end

  // calibration min/max and threshold midpoint
  assign max_pix = (s1_luma_r > row_max_r) ? s1_luma_r : row_max_r;
  assign min_pix = (s1_luma_r < row_min_r) ? s1_luma_r : row_min_r;
  assign mm_sum  = {1'b0, max_pix} + {1'b0, min_pix};
  assign thr_new = mm_sum[8:1];

  // tracking weight and saturating error accumulate
  assign col_live = (column_r != COL_MAX);
  assign weight   = $signed({1'b0, COL_HALF}) - $signed({1'b0, column_r});
  assign err_acc  = $signed({error_sum_r[14], error_sum_r})
                  + $signed({{(16-WW){weight[WW-1]}}, weight});

  always_comb begin
    err_pix = error_sum_r;
    if (s1_op_r == OP_TRACK && col_live && (s1_luma_r > threshold_r)) begin
      if (err_acc[15] != err_acc[14]) begin
        err_pix = err_acc[15] ? ERR_MIN : ERR_MAX;
      end else begin
        err_pix = err_acc[14:0];
      end
    end
  end

  lpds_drive_calc u_drive (
    .error_now  (err_pix),
    .error_prev (prev_error_r),
    .gain       (gain_r),
    .left_cur   (left_r),
    .right_cur  (right_r),
    .left_new   (left_calc),
    .right_new  (right_calc)
  );

  // state next values
  always_comb begin
    row_max_nxt    = row_max_r;
    row_min_nxt    = row_min_r;
    threshold_nxt  = threshold_r;
    column_nxt     = column_r;
    error_sum_nxt  = error_sum_r;
    prev_error_nxt = prev_error_r;
    left_nxt       = left_r;
    right_nxt      = right_r;
    if (s1_fire) begin
      if (s1_op_r == OP_CAL) begin
        row_max_nxt = max_pix;
        row_min_nxt = min_pix;
      end
      error_sum_nxt = err_pix;
      if (col_live) begin
        column_nxt = column_r + CW'(1);
      end
      if (s1_row_end_r) begin
        if (s1_op_r == OP_CAL) begin
          threshold_nxt = thr_new;
        end else begin
          left_nxt       = left_calc;
          right_nxt      = right_calc;
          prev_error_nxt = err_pix;
        end
        column_nxt    = '0;
        error_sum_nxt = '0;
        row_max_nxt   = MAX_RESET;
        row_min_nxt   = MIN_RESET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_max_r    <= MAX_RESET;
      row_min_r    <= MIN_RESET;
      threshold_r  <= '0;
      column_r     <= '0;
      error_sum_r  <= '0;
      prev_error_r <= '0;
      left_r       <= LEFT_RESET;
      right_r      <= RIGHT_RESET;
    end else begin
      row_max_r    <= row_max_nxt;
      row_min_r    <= row_min_nxt;
      threshold_r  <= threshold_nxt;
      column_r     <= column_nxt;
      error_sum_r  <= error_sum_nxt;
      prev_error_r <= prev_error_nxt;
      left_r       <= left_nxt;
      right_r      <= right_nxt;
    end
  end

  // result word payload
  always_comb begin
    out_kind_nxt = s1_op_r;
    if (s1_op_r == OP_CAL) begin
      out_thr_nxt   = thr_new;
      out_err_nxt   = '0;
      out_left_nxt  = left_r;
      out_right_nxt = right_r;
    end else begin
      out_thr_nxt   = threshold_r;
      out_err_nxt   = err_pix;
      out_left_nxt  = left_calc;
      out_right_nxt = right_calc;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_fire && s1_row_end_r) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && s1_row_end_r) begin
      out_kind_r  <= out_kind_nxt;
      out_thr_r   <= out_thr_nxt;
      out_err_r   <= out_err_nxt;
      out_left_r  <= out_left_nxt;
      out_right_r <= out_right_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = out_kind_r;
  assign out_threshold_out   = out_thr_r;
  assign out_line_error      = out_err_r;
  assign out_left_drive_out  = out_left_r;
  assign out_right_drive_out = out_right_r;

  // checks
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && s1_row_end_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked row end");

  a_column_bound: assert property (@(posedge clk) disable iff (!rst_n)
    column_r <= COL_MAX)
    else $error("column beyond row width");

  a_row_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_fire && s1_row_end_r) |=> (column_r == '0 && error_sum_r == '0))
    else $error("row state not cleared at row end");

  a_cal_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_THRESHOLD) |-> (out_err_r == '0))
    else $error("threshold word carries a line error");

endmodule

`default_nettype wire

>>> design/lpds_drive_calc.sv
// ----------------------------------------------------------------------------
// lpds_drive_calc: derivative drive update
// Scales the change in line error by the Q0.16 gain, applies it to both
// drives with truncation toward zero, and saturates each to 16 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module lpds_drive_calc
  import lpds_pkg::*;
(
  input  wire err_t   error_now,
  input  wire err_t   error_prev,
  input  wire gain_t  gain,
  input  wire drive_t left_cur,
  input  wire drive_t right_cur,
  output drive_t      left_new,
  output drive_t      right_new
);

  logic signed [15:0] diff;
  logic signed [32:0] prod;
  logic signed [34:0] prod_ext;

  // drive * 2^16 + delta, then divide by 2^16 toward zero and clamp
  function automatic drive_t apply_delta(input drive_t drive, input logic signed [34:0] delta);
    logic signed [34:0] scaled;
    logic signed [18:0] quot;
    drive_t             res;
    scaled = $signed({{3{drive[15]}}, drive, 16'h0000}) + delta;
    quot   = scaled[34:16];
    // floor shift rounds negatives down; bump back toward zero
    if (scaled[34] && (scaled[15:0] != 16'h0000)) begin
      quot = quot + 19'sd1;
    end
    if (quot > 19'sd32767) begin
      res = 16'sh7fff;
    end else if (quot < -19'sd32768) begin
      res = 16'sh8000;
    end else begin
      res = quot[15:0];
    end
    return res;
  endfunction

  // derivative term in Q0.16
  assign diff     = $signed({error_now[14], error_now}) - $signed({error_prev[14], error_prev});
  assign prod     = diff * $signed({1'b0, gain});
  assign prod_ext = {{2{prod[32]}}, prod};

  assign left_new  = apply_delta(left_cur, -prod_ext);
  assign right_new = apply_delta(right_cur, prod_ext);

endmodule

`default_nettype wire
